// File: hw/rtl/gcm_pkg.sv
// Package for the gradient colormap pixel unit: palette stop tables,
// sequencer state type and shared constants. No dependencies.
`default_nettype none
package gcm_pkg;

  localparam int LutEntries = 256;
  localparam int IdxW       = 8;
  localparam int NumPal     = 6;
  localparam int DivSteps   = 17;
  localparam int StopW      = 6;

  localparam logic [2:0] PAL_VIRIDIS = 3'd0;

  typedef enum logic [2:0] {
    ST_SEEK,
    ST_PREP,
    ST_DIV,
    ST_WRITE,
    ST_RUN
  } state_t;

  // Stop position in Q8.8 of the index domain.
  function automatic logic [15:0] stop_pos(input logic [StopW-1:0] k);
    case (k)
      6'd0: stop_pos = 16'd0;      6'd1: stop_pos = 16'd8486;
      6'd2: stop_pos = 16'd16320;  6'd3: stop_pos = 16'd24806;
      6'd4: stop_pos = 16'd32640;  6'd5: stop_pos = 16'd41126;
      6'd6: stop_pos = 16'd48960;  6'd7: stop_pos = 16'd57446;
      6'd8: stop_pos = 16'd65280;
      6'd9: stop_pos = 16'd0;      6'd10: stop_pos = 16'd9139;
      6'd11: stop_pos = 16'd18931; 6'd12: stop_pos = 16'd28070;
      6'd13: stop_pos = 16'd37210; 6'd14: stop_pos = 16'd46349;
      6'd15: stop_pos = 16'd56141; 6'd16: stop_pos = 16'd65280;
      6'd17: stop_pos = 16'd0;     6'd18: stop_pos = 16'd7181;
      6'd19: stop_pos = 16'd22848; 6'd20: stop_pos = 16'd32640;
      6'd21: stop_pos = 16'd42432; 6'd22: stop_pos = 16'd58099;
      6'd23: stop_pos = 16'd65280;
      6'd24: stop_pos = 16'd0;     6'd25: stop_pos = 16'd65280;
      6'd26: stop_pos = 16'd0;     6'd27: stop_pos = 16'd4570;
      6'd28: stop_pos = 16'd9139;  6'd29: stop_pos = 16'd13709;
      6'd30: stop_pos = 16'd18931; 6'd31: stop_pos = 16'd23501;
      6'd32: stop_pos = 16'd28070; 6'd33: stop_pos = 16'd32640;
      6'd34: stop_pos = 16'd37210; 6'd35: stop_pos = 16'd41779;
      6'd36: stop_pos = 16'd46349; 6'd37: stop_pos = 16'd51571;
      6'd38: stop_pos = 16'd56141; 6'd39: stop_pos = 16'd60710;
      6'd40: stop_pos = 16'd65280;
      6'd41: stop_pos = 16'd0;     6'd42: stop_pos = 16'd21542;
      6'd43: stop_pos = 16'd43085; 6'd44: stop_pos = 16'd65280;
      default: stop_pos = 16'd65280;
    endcase
  endfunction

  // Stop color packed as {red, green, blue, alpha}.
  function automatic logic [31:0] stop_rgba(input logic [StopW-1:0] k);
    case (k)
      6'd0: stop_rgba = {8'd68, 8'd1, 8'd84, 8'd255};
      6'd1: stop_rgba = {8'd72, 8'd35, 8'd116, 8'd255};
      6'd2: stop_rgba = {8'd64, 8'd67, 8'd135, 8'd255};
      6'd3: stop_rgba = {8'd52, 8'd94, 8'd141, 8'd255};
      6'd4: stop_rgba = {8'd33, 8'd144, 8'd140, 8'd255};
      6'd5: stop_rgba = {8'd53, 8'd183, 8'd121, 8'd255};
      6'd6: stop_rgba = {8'd109, 8'd205, 8'd89, 8'd255};
      6'd7: stop_rgba = {8'd180, 8'd222, 8'd44, 8'd255};
      6'd8: stop_rgba = {8'd253, 8'd231, 8'd37, 8'd255};
      6'd9: stop_rgba = {8'd0, 8'd0, 8'd4, 8'd255};
      6'd10: stop_rgba = {8'd40, 8'd11, 8'd84, 8'd255};
      6'd11: stop_rgba = {8'd101, 8'd21, 8'd110, 8'd255};
      6'd12: stop_rgba = {8'd159, 8'd42, 8'd99, 8'd255};
      6'd13: stop_rgba = {8'd212, 8'd72, 8'd66, 8'd255};
      6'd14: stop_rgba = {8'd245, 8'd125, 8'd21, 8'd255};
      6'd15: stop_rgba = {8'd250, 8'd193, 8'd39, 8'd255};
      6'd16: stop_rgba = {8'd252, 8'd255, 8'd164, 8'd255};
      6'd17: stop_rgba = {8'd0, 8'd0, 8'd127, 8'd255};
      6'd18: stop_rgba = {8'd0, 8'd0, 8'd255, 8'd255};
      6'd19: stop_rgba = {8'd0, 8'd255, 8'd255, 8'd255};
      6'd20: stop_rgba = {8'd0, 8'd255, 8'd0, 8'd255};
      6'd21: stop_rgba = {8'd255, 8'd255, 8'd0, 8'd255};
      6'd22: stop_rgba = {8'd255, 8'd0, 8'd0, 8'd255};
      6'd23: stop_rgba = {8'd127, 8'd0, 8'd0, 8'd255};
      6'd24: stop_rgba = {8'd0, 8'd0, 8'd0, 8'd255};
      6'd25: stop_rgba = {8'd255, 8'd255, 8'd255, 8'd255};
      6'd26: stop_rgba = {8'd48, 8'd18, 8'd59, 8'd255};
      6'd27: stop_rgba = {8'd69, 8'd55, 8'd129, 8'd255};
      6'd28: stop_rgba = {8'd66, 8'd100, 8'd190, 8'd255};
      6'd29: stop_rgba = {8'd35, 8'd141, 8'd227, 8'd255};
      6'd30: stop_rgba = {8'd7, 8'd178, 8'd222, 8'd255};
      6'd31: stop_rgba = {8'd24, 8'd207, 8'd174, 8'd255};
      6'd32: stop_rgba = {8'd78, 8'd226, 8'd120, 8'd255};
      6'd33: stop_rgba = {8'd149, 8'd237, 8'd67, 8'd255};
      6'd34: stop_rgba = {8'd202, 8'd237, 8'd36, 8'd255};
      6'd35: stop_rgba = {8'd241, 8'd213, 8'd19, 8'd255};
      6'd36: stop_rgba = {8'd254, 8'd176, 8'd10, 8'd255};
      6'd37: stop_rgba = {8'd249, 8'd131, 8'd6, 8'd255};
      6'd38: stop_rgba = {8'd225, 8'd85, 8'd5, 8'd255};
      6'd39: stop_rgba = {8'd184, 8'd43, 8'd4, 8'd255};
      6'd40: stop_rgba = {8'd122, 8'd4, 8'd3, 8'd255};
      6'd41: stop_rgba = {8'd0, 8'd0, 8'd255, 8'd255};
      6'd42: stop_rgba = {8'd0, 8'd255, 8'd0, 8'd255};
      6'd43: stop_rgba = {8'd255, 8'd255, 8'd0, 8'd255};
      6'd44: stop_rgba = {8'd255, 8'd0, 8'd0, 8'd255};
      default: stop_rgba = {8'd0, 8'd0, 8'd0, 8'd255};
    endcase
  endfunction

  function automatic logic [StopW-1:0] pal_first(input logic [2:0] p);
    case (p)
      3'd1: pal_first = 6'd9;
      3'd2: pal_first = 6'd17;
      3'd3: pal_first = 6'd24;
      3'd4: pal_first = 6'd26;
      3'd5: pal_first = 6'd41;
      default: pal_first = 6'd0;
    endcase
  endfunction

  // Index of the last stop within the palette (count minus one).
  function automatic logic [3:0] pal_last(input logic [2:0] p);
    case (p)
      3'd1: pal_last = 4'd7;
      3'd2: pal_last = 4'd6;
      3'd3: pal_last = 4'd1;
      3'd4: pal_last = 4'd14;
      3'd5: pal_last = 4'd3;
      default: pal_last = 4'd8;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no dependencies.
`default_nettype none
module gcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/gradient_colormap_pixel_unit.sv
// Top level of the gradient colormap pixel unit: colormap table builder and
// pixel lookup path. Uses gcm_pkg and gcm_ram.
`default_nettype none
// The unit maps a 16-bit intensity level to an RGBA color of one of six
// built-in palettes. It keeps a 256-entry color table in a synchronous RAM.
// After reset, and after every write of palette_select, a sequencer rebuilds
// that table: for each of the 256 indexes it walks to the palette segment
// (one stop per cycle, moving forward only), forms the Q1.16 segment fraction
// in a radix-2 divider and interpolates the four channels. During a rebuild
// in_ready stays low while the configuration port keeps working. Once the
// table is built, the unit takes one item every clock: the level is reduced
// to an index (level/257, done with a compare instead of a divider), the RAM
// is read and its registered data is the result in the next cycle. A result
// held by a stalled consumer stops new items only until it is taken.
module gradient_colormap_pixel_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  red,
  output logic      [7:0]  green,
  output logic      [7:0]  blue,
  output logic      [7:0]  alpha
);

  gcm_pkg::state_t state, state_next;

  logic [2:0]  palette;
  logic        cfg_wr;
  logic [7:0]  idx;
  logic [3:0]  up;
  logic [4:0]  div_cnt;
  logic [23:0] den;
  logic [23:0] rem;
  logic [16:0] src_low;
  logic [16:0] quot;
  logic [31:0] lo_rgba;
  logic [31:0] hi_rgba;

  // Stop lookup for the current segment.
  logic [5:0]  k_hi;
  logic [5:0]  k_lo;
  logic [15:0] pos_hi;
  logic [15:0] pos_lo;
  logic        seek_more;
  logic [23:0] plo;
  logic [23:0] phi;
  logic [23:0] target;
  logic        do_div;
  logic [40:0] dividend;
  logic [24:0] trial;
  logic        trial_ge;
  logic [16:0] frac;
  logic [31:0] color;

  // Lookup path.
  logic        accept;
  logic [7:0]  lvl_idx;
  logic [31:0] ram_rdata;
  logic        ram_we;

  assign pready = 1'b1;
  assign prdata = {29'd0, palette};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      palette <= gcm_pkg::PAL_VIRIDIS;
    end else if (cfg_wr) begin
      palette <= pwdata[2:0];
    end
  end

  // Codes six and seven fall back to the first palette.
  logic [2:0] pal_eff;
  assign pal_eff = (palette < 3'(gcm_pkg::NumPal)) ? palette : gcm_pkg::PAL_VIRIDIS;

  assign k_hi   = gcm_pkg::pal_first(pal_eff) + 6'(up);
  assign k_lo   = k_hi - 6'd1;
  assign pos_hi = gcm_pkg::stop_pos(k_hi);
  assign pos_lo = gcm_pkg::stop_pos(k_lo);
  // pos*255 < idx*65280 is the same test as pos < idx*256.
  assign seek_more = (up < gcm_pkg::pal_last(pal_eff)) && (pos_hi < {idx, 8'h00});

  // Positions and target scaled by LUT_ENTRIES-1 = 255 (x*256 - x).
  assign plo    = {pos_lo, 8'h00} - {8'h00, pos_lo};
  assign phi    = {pos_hi, 8'h00} - {8'h00, pos_hi};
  assign target = {idx, 16'h0000} - {8'h00, idx, 8'h00};
  assign do_div = (phi > plo) && (target > plo);
  assign dividend = {target - plo, 16'h0000} + 41'({1'b0, phi - plo} >> 1);

  // One restoring division step per cycle.
  assign trial    = {rem, src_low[16]};
  assign trial_ge = trial >= {1'b0, den};

  // The fraction never exceeds one in practice; saturate anyway.
  assign frac = (quot > 17'd65536) ? 17'd65536 : quot;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [8:0]  diff;
      logic signed [26:0] acc;
      diff = $signed({1'b0, hi_rgba[c*8 +: 8]}) - $signed({1'b0, lo_rgba[c*8 +: 8]});
      acc  = $signed({3'b000, lo_rgba[c*8 +: 8], 16'h0000})
           + diff * $signed({1'b0, frac})
           + 27'sd32768;
      color[c*8 +: 8] = acc[23:16];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gcm_pkg::ST_SEEK:  state_next = seek_more ? gcm_pkg::ST_SEEK : gcm_pkg::ST_PREP;
      gcm_pkg::ST_PREP:  state_next = do_div ? gcm_pkg::ST_DIV : gcm_pkg::ST_WRITE;
      gcm_pkg::ST_DIV: begin
        if (div_cnt == 5'(gcm_pkg::DivSteps - 1)) begin
          state_next = gcm_pkg::ST_WRITE;
        end
      end
      gcm_pkg::ST_WRITE: state_next = (idx == 8'hFF) ? gcm_pkg::ST_RUN : gcm_pkg::ST_SEEK;
      gcm_pkg::ST_RUN:   state_next = gcm_pkg::ST_RUN;
      default:           state_next = gcm_pkg::ST_SEEK;
    endcase
    if (cfg_wr) begin
      state_next = gcm_pkg::ST_SEEK;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    ram_we   = 1'b0;
    in_ready = 1'b0;
    unique case (state)
      gcm_pkg::ST_WRITE: ram_we = 1'b1;
      gcm_pkg::ST_RUN:   in_ready = !out_valid || out_ready;
      default: begin
        ram_we   = 1'b0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::ST_SEEK;
      idx   <= 8'd0;
      up    <= 4'd1;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        idx <= 8'd0;
        up  <= 4'd1;
      end else if (state == gcm_pkg::ST_SEEK && seek_more) begin
        up <= up + 4'd1;
      end else if (state == gcm_pkg::ST_WRITE) begin
        idx <= idx + 8'd1;
      end
    end
  end

  // Divider and segment registers.
  always_ff @(posedge clk) begin
    if (state == gcm_pkg::ST_PREP) begin
      lo_rgba <= gcm_pkg::stop_rgba(k_lo);
      hi_rgba <= gcm_pkg::stop_rgba(k_hi);
      den     <= phi - plo;
      rem     <= dividend[40:17];
      src_low <= dividend[16:0];
      quot    <= 17'd0;
      div_cnt <= 5'd0;
    end else if (state == gcm_pkg::ST_DIV) begin
      rem     <= trial_ge ? 24'(trial - {1'b0, den}) : trial[23:0];
      src_low <= {src_low[15:0], 1'b0};
      quot    <= {quot[15:0], trial_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // level/257: the high byte is the index or one above it.
  assign lvl_idx = (level < {level[15:8], level[15:8]}) ? level[15:8] - 8'd1 : level[15:8];
  assign accept  = in_valid && in_ready;

  gcm_ram #(
    .WIDTH(32),
    .DEPTH(gcm_pkg::LutEntries)
  ) u_lut (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (color),
    .re    (accept),
    .raddr (lvl_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign red   = ram_rdata[31:24];
  assign green = ram_rdata[23:16];
  assign blue  = ram_rdata[15:8];
  assign alpha = ram_rdata[7:0];

  // An accepted item always yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> out_valid)
    else $error("accepted item produced no result");

  // The table is never written while items are being looked up.
  assert property (@(posedge clk) disable iff (rst) !(ram_we && in_ready))
    else $error("table written while lookups are open");

  // The divider never runs past its step count.
  assert property (@(posedge clk) disable iff (rst)
    (state == gcm_pkg::ST_DIV) |-> (div_cnt < 5'(gcm_pkg::DivSteps)))
    else $error("divider step count overrun");

endmodule
`default_nettype wire
